[design/rc4_pkg.sv]
package rc4_pkg;

  localparam int unsigned PERM_SIZE     = 256;
  localparam int unsigned IDX_W         = $clog2(PERM_SIZE);
  localparam int unsigned MAX_KEY_BYTES = 16;
  localparam int unsigned KEY_W         = MAX_KEY_BYTES * 8;
  localparam int unsigned KSEL_W        = $clog2(MAX_KEY_BYTES);
  localparam int unsigned KLEN_W        = 5;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 64;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [7:0]        byte_t;
  typedef logic [KSEL_W-1:0] ksel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LOW    = 3'd0,
    REG_KEY_HIGH   = 3'd1,
    REG_KEY_LENGTH = 3'd2,
    REG_USE_RC4    = 3'd3,
    REG_XOR_BYTE   = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_XOR,
    ST_INIT,
    ST_KSA_RD,
    ST_KSA_B,
    ST_KSA_WA,
    ST_KSA_WB,
    ST_COPY,
    ST_COPY_LAST,
    ST_KS1,
    ST_KS2,
    ST_KS3,
    ST_KS4,
    ST_HOLD
  } ctrl_state_e;

  // key schedule operations on the scheduled table
  typedef enum logic [2:0] {
    SOP_NONE,
    SOP_INIT,
    SOP_STEP_B,
    SOP_WRITE_A,
    SOP_WRITE_B
  } sop_e;

  // keystream operations on the working table
  typedef enum logic [1:0] {
    WOP_NONE,
    WOP_READ_J,
    WOP_SWAP_I,
    WOP_SWAP_J
  } wop_e;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_XOR,
    OUT_KS,
    OUT_HELD
  } out_sel_e;

  typedef struct packed {
    logic     start;
    logic     a_inc;
    sop_e     sop;
    logic     copy_wr;
    wop_e     wop;
    logic     stream_clr;
    out_sel_e out_sel;
  } rc4_cmd_t;

  typedef struct packed {
    logic a_first;
    logic a_last;
  } rc4_status_t;

  // key length minus one, with zero taken as one and saturation at the maximum
  function automatic ksel_t key_len_m1(input logic [KLEN_W-1:0] len);
    ksel_t res;
    if (len == '0) begin
      res = '0;
    end else if (len > KLEN_W'(MAX_KEY_BYTES)) begin
      res = ksel_t'(MAX_KEY_BYTES - 1);
    end else begin
      res = ksel_t'(len - KLEN_W'(1));
    end
    return res;
  endfunction

endpackage

[design/rc4_stream_cipher_unit.sv]
// Channel | Signals                                     | Direction
// input   | in_valid_i, in_stall_o, data_in_i,          | in
//         | first_of_message_i                          |
// output  | out_valid_o, out_stall_i, data_out_o        | out
// config  | cfg_valid_i, cfg_ready_o, cfg_index_i,      | in
//         | cfg_data_i                                  |
//
// One word in flight; an RC4 word steps through two dependent reads, the swap write-back
// and the output read on the working table, an XOR-mode word through the XOR state.
// First RC4 word after reset or a config write adds a key schedule (an init pass, then read,
// step-b, write-a and write-b states per step); first_of_message adds a table copy; either adds ST_KS1.
// Reset clears control and stream indices and loads config defaults; tables are unset.
// A stalled output is held in a register while the next word may already be taken.
module rc4_stream_cipher_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     data_in_i,
  input  logic                           first_of_message_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     data_out_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rc4_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rc4_pkg::*;

  logic [CFG_DATA_W-1:0] key_low_q, key_high_q;
  logic [KLEN_W-1:0]     key_length_q;
  logic                  use_rc4_q;
  byte_t                 xor_byte_q;
  logic                  cfg_hit;

  rc4_cmd_t    cmd;
  rc4_status_t status;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    unique case (cfg_reg_e'(cfg_index_i))
      REG_KEY_LOW, REG_KEY_HIGH, REG_KEY_LENGTH,
      REG_USE_RC4, REG_XOR_BYTE: cfg_hit = cfg_valid_i;
      default:                   cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q    <= '0;
      key_high_q   <= '0;
      key_length_q <= KLEN_W'(MAX_KEY_BYTES);
      use_rc4_q    <= 1'b1;
      xor_byte_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_KEY_LOW:    key_low_q    <= cfg_data_i;
        REG_KEY_HIGH:   key_high_q   <= cfg_data_i;
        REG_KEY_LENGTH: key_length_q <= cfg_data_i[KLEN_W-1:0];
        REG_USE_RC4:    use_rc4_q    <= cfg_data_i[0];
        REG_XOR_BYTE:   xor_byte_q   <= cfg_data_i[7:0];
        default:        key_low_q    <= key_low_q;
      endcase
    end
  end

  rc4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .first_i     (first_of_message_i),
    .use_rc4_i   (use_rc4_q),
    .cfg_wr_i    (cfg_hit),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  rc4_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .data_in_i    (data_in_i),
    .key_i        ({key_high_q, key_low_q}),
    .key_length_i (key_length_q),
    .xor_byte_i   (xor_byte_q),
    .status_o     (status),
    .data_out_o   (data_out_o)
  );

  // only one word in flight
  a_single_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second word taken while one is in flight");

  // a result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_sel != OUT_NONE) |-> (!out_valid_o || !out_stall_i))
    else $error("output register overwritten");

  // table copy never shares the working table port with keystream work
  a_copy_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.copy_wr |-> (cmd.wop == WOP_NONE))
    else $error("copy collides with keystream access");

endmodule

[design/rc4_ctrl.sv]
module rc4_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                first_i,
  input  logic                use_rc4_i,
  input  logic                cfg_wr_i,
  input  logic                out_stall_i,
  input  rc4_pkg::rc4_status_t status_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output rc4_pkg::rc4_cmd_t   cmd_o
);
  import rc4_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        sched_done_q, sched_done_d;
  logic        first_q, first_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;
  logic        out_free;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      sched_done_q <= 1'b0;
      first_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      sched_done_q <= sched_done_d;
      first_q      <= first_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    sched_done_d = sched_done_q;
    first_d      = first_q;
    cmd_o        = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.start = 1'b1;
          first_d     = first_i;
          if (!use_rc4_i) begin
            state_d = ST_XOR;
          end else if (!sched_done_q) begin
            state_d = ST_INIT;
          end else if (first_i) begin
            state_d = ST_COPY;
          end else begin
            // working table read of entry i+1 was issued this cycle
            state_d = ST_KS2;
          end
        end
      end
      ST_XOR: begin
        if (out_free) begin
          cmd_o.out_sel = OUT_XOR;
          state_d       = ST_IDLE;
        end
      end
      ST_INIT: begin
        cmd_o.sop   = SOP_INIT;
        cmd_o.a_inc = 1'b1;
        if (status_i.a_last) begin
          state_d = ST_KSA_RD;
        end
      end
      ST_KSA_RD: begin
        state_d = ST_KSA_B;
      end
      ST_KSA_B: begin
        cmd_o.sop = SOP_STEP_B;
        state_d   = ST_KSA_WA;
      end
      ST_KSA_WA: begin
        cmd_o.sop = SOP_WRITE_A;
        state_d   = ST_KSA_WB;
      end
      ST_KSA_WB: begin
        cmd_o.sop   = SOP_WRITE_B;
        cmd_o.a_inc = 1'b1;
        if (status_i.a_last) begin
          sched_done_d = 1'b1;
          state_d      = first_q ? ST_COPY : ST_KS1;
        end else begin
          state_d = ST_KSA_RD;
        end
      end
      ST_COPY: begin
        // read entry a, write entry a-1 with the word read last cycle
        cmd_o.a_inc   = 1'b1;
        cmd_o.copy_wr = !status_i.a_first;
        if (status_i.a_last) begin
          state_d = ST_COPY_LAST;
        end
      end
      ST_COPY_LAST: begin
        cmd_o.copy_wr    = 1'b1;
        cmd_o.stream_clr = 1'b1;
        state_d          = ST_KS1;
      end
      ST_KS1: begin
        state_d = ST_KS2;
      end
      ST_KS2: begin
        cmd_o.wop = WOP_READ_J;
        state_d   = ST_KS3;
      end
      ST_KS3: begin
        cmd_o.wop = WOP_SWAP_I;
        state_d   = ST_KS4;
      end
      ST_KS4: begin
        cmd_o.wop = WOP_SWAP_J;
        if (out_free) begin
          cmd_o.out_sel = OUT_KS;
          state_d       = ST_IDLE;
        end else begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd_o.out_sel = OUT_HELD;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cfg_wr_i) begin
      sched_done_d = 1'b0;
    end
  end

  always_comb begin
    if (cmd_o.out_sel != OUT_NONE) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[design/rc4_datapath.sv]
module rc4_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rc4_pkg::rc4_cmd_t             cmd_i,
  input  logic [7:0]                    data_in_i,
  input  logic [rc4_pkg::KEY_W-1:0]     key_i,
  input  logic [rc4_pkg::KLEN_W-1:0]    key_length_i,
  input  logic [7:0]                    xor_byte_i,
  output rc4_pkg::rc4_status_t          status_o,
  output logic [7:0]                    data_out_o
);
  import rc4_pkg::*;

  byte_t sched_mem [PERM_SIZE];
  byte_t work_mem  [PERM_SIZE];

  idx_t  a_q, b_q, si_q, sj_q;
  ksel_t k_q, len_m1_q;
  byte_t sa_q, wi_q, wj_q, res_q, data_q, out_q;
  byte_t sched_rd_q, work_rd_q;

  idx_t  b_new, sj_new, ks_sum;
  byte_t key_byte, ks_byte, ks_res;

  logic  sched_we, work_we;
  idx_t  sched_wa, sched_ra, work_wa, work_ra;
  byte_t sched_wd, work_wd;

  assign key_byte = key_i[{k_q, 3'b000} +: 8];
  assign b_new    = idx_t'(b_q + sched_rd_q + key_byte);
  assign sj_new   = idx_t'(sj_q + work_rd_q);
  assign ks_sum   = idx_t'(wi_q + wj_q);

  // the read of entry i+j saw the table before the swap; patch it here
  always_comb begin
    if (ks_sum == si_q) begin
      ks_byte = wj_q;
    end else if (ks_sum == sj_q) begin
      ks_byte = wi_q;
    end else begin
      ks_byte = work_rd_q;
    end
  end
  assign ks_res = data_q ^ ks_byte;

  always_comb begin
    sched_we = 1'b0;
    sched_wa = a_q;
    sched_wd = a_q;
    case (cmd_i.sop)
      SOP_INIT: begin
        sched_we = 1'b1;
      end
      SOP_WRITE_A: begin
        sched_we = 1'b1;
        sched_wd = sched_rd_q;
      end
      SOP_WRITE_B: begin
        sched_we = 1'b1;
        sched_wa = b_q;
        sched_wd = sa_q;
      end
      default: begin
        sched_we = 1'b0;
      end
    endcase
    sched_ra = (cmd_i.sop == SOP_STEP_B) ? b_new : a_q;
  end

  always_comb begin
    work_we = 1'b0;
    work_wa = idx_t'(a_q - idx_t'(1));
    work_wd = sched_rd_q;
    work_ra = idx_t'(si_q + idx_t'(1));
    if (cmd_i.copy_wr) begin
      work_we = 1'b1;
    end
    case (cmd_i.wop)
      WOP_READ_J: begin
        work_ra = sj_new;
      end
      WOP_SWAP_I: begin
        work_we = 1'b1;
        work_wa = si_q;
        work_wd = work_rd_q;
        work_ra = idx_t'(wi_q + work_rd_q);
      end
      WOP_SWAP_J: begin
        work_we = 1'b1;
        work_wa = sj_q;
        work_wd = wi_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (sched_we) begin
      sched_mem[sched_wa] <= sched_wd;
    end
    sched_rd_q <= sched_mem[sched_ra];
  end

  always_ff @(posedge clk_i) begin
    if (work_we) begin
      work_mem[work_wa] <= work_wd;
    end
    work_rd_q <= work_mem[work_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q  <= '0;
      b_q  <= '0;
      k_q  <= '0;
      si_q <= '0;
      sj_q <= '0;
    end else begin
      if (cmd_i.start) begin
        a_q <= '0;
        b_q <= '0;
        k_q <= '0;
      end else begin
        if (cmd_i.a_inc) begin
          a_q <= idx_t'(a_q + idx_t'(1));
        end
        if (cmd_i.sop == SOP_STEP_B) begin
          b_q <= b_new;
        end
        if (cmd_i.sop == SOP_WRITE_B) begin
          k_q <= (k_q == len_m1_q) ? '0 : ksel_t'(k_q + ksel_t'(1));
        end
      end
      if (cmd_i.stream_clr) begin
        si_q <= '0;
        sj_q <= '0;
      end else if (cmd_i.wop == WOP_READ_J) begin
        si_q <= idx_t'(si_q + idx_t'(1));
        sj_q <= sj_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      len_m1_q <= key_len_m1(key_length_i);
      data_q   <= data_in_i;
    end
    if (cmd_i.sop == SOP_STEP_B) begin
      sa_q <= sched_rd_q;
    end
    if (cmd_i.wop == WOP_READ_J) begin
      wi_q <= work_rd_q;
    end
    if (cmd_i.wop == WOP_SWAP_I) begin
      wj_q <= work_rd_q;
    end
    if (cmd_i.wop == WOP_SWAP_J) begin
      res_q <= ks_res;
    end
    case (cmd_i.out_sel)
      OUT_XOR:  out_q <= data_q ^ xor_byte_i;
      OUT_KS:   out_q <= ks_res;
      OUT_HELD: out_q <= res_q;
      default:  out_q <= out_q;
    endcase
  end

  assign status_o.a_first = (a_q == '0);
  assign status_o.a_last  = (a_q == idx_t'(PERM_SIZE - 1));
  assign data_out_o       = out_q;

endmodule

[tb/rc4_stream_cipher_unit_tb.sv]
module rc4_stream_cipher_unit_tb;
  import rc4_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned LONG_HOLD   = 400;

  class rc4_shadow;
    bit [63:0]  key_lo;
    bit [63:0]  key_hi;
    bit [4:0]   key_len;
    bit         rc4_mode;
    bit [7:0]   fixed_byte;
    bit [7:0]   sched_tbl[PERM_SIZE];
    bit [7:0]   work_tbl[PERM_SIZE];
    bit [7:0]   si;
    bit [7:0]   sj;
    bit         sched_valid;
    bit         perm_loaded;
    bit [7:0]   due_bytes[$];
    int unsigned errors;

    function new();
      key_lo      = '0;
      key_hi      = '0;
      key_len     = 5'd16;
      rc4_mode    = 1'b1;
      fixed_byte  = '0;
      si          = '0;
      sj          = '0;
      sched_valid = 1'b0;
      perm_loaded = 1'b0;
      errors      = 0;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
      case (idx)
        REG_KEY_LOW:    key_lo = val;
        REG_KEY_HIGH:   key_hi = val;
        REG_KEY_LENGTH: key_len = val[4:0];
        REG_USE_RC4:    rc4_mode = val[0];
        REG_XOR_BYTE:   fixed_byte = val[7:0];
        default:        return;
      endcase
      sched_valid = 1'b0;
    endfunction

    function int unsigned pending();
      return due_bytes.size();
    endfunction

    // key schedule over the current key, zero length taken as one, long saturated
    function void run_key_schedule();
      int unsigned n;
      int unsigned len;
      bit [7:0]    b;
      bit [7:0]    t;
      len = key_len;
      if (len == 0) len = 1;
      if (len > MAX_KEY_BYTES) len = MAX_KEY_BYTES;
      for (n = 0; n < PERM_SIZE; n++) sched_tbl[n] = n[7:0];
      b = '0;
      for (n = 0; n < PERM_SIZE; n++) begin
        b = b + sched_tbl[n] + 8'({key_hi, key_lo} >> (8 * (n % len)));
        t = sched_tbl[n];
        sched_tbl[n] = sched_tbl[b];
        sched_tbl[b] = t;
      end
      sched_valid = 1'b1;
    endfunction

    function void absorb_word(input bit [7:0] d, input bit f);
      bit [7:0] t;
      bit [7:0] ks;
      if (!rc4_mode) begin
        due_bytes.push_back(d ^ fixed_byte);
        return;
      end
      if (!sched_valid) run_key_schedule();
      if (f) begin
        work_tbl    = sched_tbl;
        si          = '0;
        sj          = '0;
        perm_loaded = 1'b1;
      end
      si = si + 8'd1;
      sj = sj + work_tbl[si];
      t = work_tbl[si];
      work_tbl[si] = work_tbl[sj];
      work_tbl[sj] = t;
      ks = work_tbl[8'(work_tbl[si] + work_tbl[sj])];
      due_bytes.push_back(d ^ ks);
    endfunction

    function void match_word(input bit [7:0] act);
      bit [7:0] want;
      if (due_bytes.size() == 0) begin
        $display("%0t: data_out %02h with no word pending", $time, act);
        errors++;
        return;
      end
      want = due_bytes.pop_front();
      if (want !== act) begin
        $display("%0t: data_out mismatch, expected %02h, actual %02h", $time, want, act);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [7:0]            data_in_i;
  logic                  first_of_message_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [7:0]            data_out_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rc4_shadow   sb;
  bit          hold_request;
  int unsigned burst_left;

  rc4_stream_cipher_unit dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.match_word(data_out_o);
  end

  initial begin : stall_pattern
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned mode;
    int unsigned tick;
    bit          hold_used;
    hold_left = 0;
    mode_left = 0;
    mode = 0;
    tick = 0;
    hold_used = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_request && !hold_used) begin
        hold_used = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(40, 300);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 2) == 0);
          2:       out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= (tick % 4 == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // sender bursts: valid stays high inside a burst, drops for a gap between bursts
  task automatic send_word(input bit [7:0] d, input bit f);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 30)) @(posedge clk_i);
      else repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i         <= 1'b1;
    data_in_i          <= d;
    first_of_message_i <= f;
    do @(posedge clk_i); while (in_stall_o);
    sb.absorb_word(d, f);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // cfg_valid stays high across back-to-back writes; caller drops it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
  endtask

  task automatic random_setup();
    logic [63:0] v;
    if ($urandom_range(0, 2) != 0) write_reg(REG_KEY_LOW, {$urandom, $urandom});
    if ($urandom_range(0, 2) != 0) write_reg(REG_KEY_HIGH, {$urandom, $urandom});
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       v[4:0] = 5'd0;
      1:       v[4:0] = 5'd16;
      2:       v[4:0] = 5'd31;
      3:       v[4:0] = 5'd1;
      default: v[4:0] = 5'($urandom_range(1, 16));
    endcase
    write_reg(REG_KEY_LENGTH, v);
    if ($urandom_range(0, 1) == 0) write_reg(REG_XOR_BYTE, {$urandom, $urandom});
    v = {$urandom, $urandom};
    v[0] = ($urandom_range(0, 3) != 0);
    write_reg(REG_USE_RC4, v);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly well-formed messages; now and then a restart inside a message
  task automatic random_traffic(input int unsigned n_words);
    int unsigned k;
    int unsigned msg_left;
    bit          f;
    msg_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 10);
    for (k = 0; k < n_words; k++) begin
      if (msg_left == 0) begin
        case ($urandom_range(0, 39))
          0:       msg_left = $urandom_range(260, 400);
          1, 2, 3: msg_left = $urandom_range(30, 120);
          default: msg_left = $urandom_range(1, 16);
        endcase
        f = 1'b1;
      end else begin
        f = ($urandom_range(0, 19) == 0);
      end
      msg_left--;
      if (sb.rc4_mode && !sb.perm_loaded) f = 1'b1;
      send_word(8'($urandom), f);
    end
  endtask

  initial begin : main
    int unsigned k;
    sb = new();
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    data_in_i          = '0;
    first_of_message_i = 1'b0;
    cfg_valid_i        = 1'b0;
    cfg_index_i        = '0;
    cfg_data_i         = '0;
    hold_request       = 1'b0;
    burst_left         = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: all-zero key of full length, restart inside a message
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b0);
    send_word(8'hA5, 1'b0);
    send_word(8'h5A, 1'b1);
    send_word(8'h00, 1'b0);
    drain();

    // zero key length acts as one; old working table carries on until a restart
    write_reg(REG_KEY_LENGTH, 64'd0);
    cfg_valid_i <= 1'b0;
    send_word(8'h11, 1'b0);
    send_word(8'h22, 1'b1);
    send_word(8'h33, 1'b0);
    drain();

    write_reg(REG_KEY_LOW, '1);
    write_reg(REG_KEY_HIGH, '1);
    write_reg(REG_KEY_LENGTH, 64'd16);
    cfg_valid_i <= 1'b0;
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b0);
    send_word(8'h3C, 1'b0);
    drain();

    // lengths past the maximum saturate
    write_reg(REG_KEY_LOW, 64'h0123_4567_89AB_CDEF);
    write_reg(REG_KEY_HIGH, 64'hFEDC_BA98_7654_3210);
    write_reg(REG_KEY_LENGTH, 64'd31);
    cfg_valid_i <= 1'b0;
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b0);
    drain();
    write_reg(REG_KEY_LENGTH, 64'd17);
    cfg_valid_i <= 1'b0;
    send_word(8'h80, 1'b1);
    drain();

    // fixed-byte mode ignores first_of_message
    write_reg(REG_USE_RC4, 64'd0);
    write_reg(REG_XOR_BYTE, 64'hFF);
    cfg_valid_i <= 1'b0;
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b0);
    send_word(8'h0F, 1'b1);
    drain();
    write_reg(REG_XOR_BYTE, 64'hFFFF_FFFF_FFFF_FF00);
    cfg_valid_i <= 1'b0;
    send_word(8'hC3, 1'b0);
    drain();

    // indexes past the register list do nothing
    for (k = int'(REG_XOR_BYTE) + 1; k < (1 << CFG_IDX_W); k++) begin
      write_reg(CFG_IDX_W'(k), {$urandom, $urandom});
    end
    write_reg(REG_USE_RC4, 64'h1);
    cfg_valid_i <= 1'b0;
    send_word(8'h55, 1'b0);
    drain();

    for (k = 0; k < 8; k++) begin
      random_setup();
      if (k == 2) hold_request = 1'b1;
      random_traffic(172);
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/rc4_pkg.sv
design/rc4_ctrl.sv
design/rc4_datapath.sv
design/rc4_stream_cipher_unit.sv
tb/rc4_stream_cipher_unit_tb.sv
